>>> sv/swaabb_pkg.sv
// ----------------------------------------------------------------------------
// Swept AABB fraction package
// Shared register indexes and widths of the swept box test.
// ----------------------------------------------------------------------------
`default_nettype none
package swaabb_pkg;

  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSkinMargin = 1'b0,
    CfgParThresh  = 1'b1
  } cfg_reg_e;

  localparam logic [CfgDataW-1:0] SkinReset = 16'd66;
  localparam logic [CfgDataW-1:0] ThrReset  = 16'd7;

endpackage
`default_nettype wire

>>> sv/swept_aabb_fraction_core.sv
// ----------------------------------------------------------------------------
// Swept AABB fraction core
// Point sweep against a box: separating axes x, y and move perpendicular.
// ----------------------------------------------------------------------------
// The input channel takes one query beat per cycle unless the output is stalled:
// start, move and box center in signed fixed point, half size unsigned. The output
// channel returns the allowed share of the move and a hit flag. The configuration
// channel writes the skin margin (index 0) and the parallel threshold (index 1);
// it is always ready. The throughput is one beat per cycle unless the output is
// stalled. The depth comes from the restoring divide, one quotient bit per stage,
// behind two stages of compare and multiply and ahead of the output register.
// All stages move together; while the output beat is stalled the whole
// pipeline holds and the input is stalled in the same cycle.
// Reset empties the pipeline and loads the registers with their defaults.
// ----------------------------------------------------------------------------
`default_nettype none
module swept_aabb_fraction_core #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire         [swaabb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire         [swaabb_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  wire  signed [COORD_WIDTH-1:0]        start_x_i,
  input  wire  signed [COORD_WIDTH-1:0]        start_y_i,
  input  wire  signed [COORD_WIDTH-1:0]        move_x_i,
  input  wire  signed [COORD_WIDTH-1:0]        move_y_i,
  input  wire  signed [COORD_WIDTH-1:0]        box_center_x_i,
  input  wire  signed [COORD_WIDTH-1:0]        box_center_y_i,
  input  wire         [COORD_WIDTH-2:0]        box_half_w_i,
  input  wire         [COORD_WIDTH-2:0]        box_half_h_i,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output logic        [FRAC_BITS:0]            allowed_fraction_o,
  output logic                                 hit_o
);
  import swaabb_pkg::*;

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned N  = F + 3;
  localparam int unsigned PW = 2 * W + 4;
  localparam logic [F:0] One = {1'b1, {F{1'b0}}};

  logic [CfgDataW-1:0] skin_q, thr_q;
  logic                en;
  logic [N-1:0]        v_q;

  assign cfg_ready_o = 1'b1;
  assign en          = !(v_q[N-1] && out_stall_i);
  assign in_stall_o  = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skin_q <= SkinReset;
      thr_q  <= ThrReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgSkinMargin: skin_q <= cfg_data_i;
        CfgParThresh:  thr_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[N-2:0], in_valid_i};
    end
  end

  logic       sep_x, sep_y;
  logic [F:0] frac_x, frac_y;

  swaabb_axis #(.COORD_WIDTH(W), .FRAC_BITS(F)) u_axis_x (
    .clk_i, .en_i(en), .p_i(start_x_i), .m_i(move_x_i), .c_i(box_center_x_i),
    .h_i(box_half_w_i), .skin_i(skin_q), .thr_i(thr_q),
    .sep_o(sep_x), .frac_o(frac_x)
  );

  swaabb_axis #(.COORD_WIDTH(W), .FRAC_BITS(F)) u_axis_y (
    .clk_i, .en_i(en), .p_i(start_y_i), .m_i(move_y_i), .c_i(box_center_y_i),
    .h_i(box_half_h_i), .skin_i(skin_q), .thr_i(thr_q),
    .sep_o(sep_y), .frac_o(frac_y)
  );

  logic signed [W:0] dx_q, dy_q, nmy_q, mx_q;
  logic        [W:0] amx_q, amy_q;
  logic      [W-2:0] hw_q, hh_q;
  logic              mnz_a_q, mnz_b_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q    <= {start_x_i[W-1], start_x_i} - {box_center_x_i[W-1], box_center_x_i};
      dy_q    <= {start_y_i[W-1], start_y_i} - {box_center_y_i[W-1], box_center_y_i};
      nmy_q   <= -{move_y_i[W-1], move_y_i};
      mx_q    <= {move_x_i[W-1], move_x_i};
      amx_q   <= move_x_i[W-1] ? -{1'b1, move_x_i} : {1'b0, move_x_i};
      amy_q   <= move_y_i[W-1] ? -{1'b1, move_y_i} : {1'b0, move_y_i};
      hw_q    <= box_half_w_i;
      hh_q    <= box_half_h_i;
      mnz_a_q <= (move_x_i != '0) || (move_y_i != '0);
    end
  end

  logic signed [2*W+1:0] p1_q, p2_q;
  logic        [2*W-1:0] e1_q, e2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q    <= nmy_q * dx_q;
      p2_q    <= mx_q * dy_q;
      e1_q    <= hw_q * amy_q;
      e2_q    <= hh_q * amx_q;
      mnz_b_q <= mnz_a_q;
    end
  end

  logic signed [PW-1:0] dsum, ext, below, above;
  logic                 sepp_c;

  always_comb begin
    dsum   = PW'(p1_q) + PW'(p2_q);
    ext    = $signed({4'b0, e1_q}) + $signed({4'b0, e2_q});
    below  = dsum + ext;
    above  = ext - dsum;
    sepp_c = mnz_b_q && ((below < 0) || (above <= 0));
  end

  logic sepp_q [F];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sepp_q[0] <= sepp_c;
      for (int k = 1; k < F; k++) begin
        sepp_q[k] <= sepp_q[k-1];
      end
    end
  end

  logic       sep_all;
  logic [F:0] frac_d, frac_q;

  always_comb begin
    sep_all = sep_x || sep_y || sepp_q[F-1];
    frac_d  = sep_all ? One : ((frac_x > frac_y) ? frac_x : frac_y);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      frac_q <= frac_d;
    end
  end

  assign out_valid_o        = v_q[N-1];
  assign allowed_fraction_o = frac_q;
  assign hit_o              = !frac_q[F];

  a_hit_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hit_o == (allowed_fraction_o != One)))
    else $error("hit flag disagrees with fraction");

  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(allowed_fraction_o[F] && (allowed_fraction_o[F-1:0] != '0)))
    else $error("fraction above full move");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(allowed_fraction_o)))
    else $error("stalled result changed");

endmodule
`default_nettype wire

>>> sv/swaabb_axis.sv
// ----------------------------------------------------------------------------
// Swept AABB axis unit
// Separation test and pipelined blocking fraction divide along one axis.
// ----------------------------------------------------------------------------
`default_nettype none
module swaabb_axis #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  wire                                  clk_i,
  input  wire                                  en_i,
  input  wire  signed [COORD_WIDTH-1:0]        p_i,
  input  wire  signed [COORD_WIDTH-1:0]        m_i,
  input  wire  signed [COORD_WIDTH-1:0]        c_i,
  input  wire         [COORD_WIDTH-2:0]        h_i,
  input  wire         [swaabb_pkg::CfgDataW-1:0] skin_i,
  input  wire         [swaabb_pkg::CfgDataW-1:0] thr_i,
  output logic                                 sep_o,
  output logic        [FRAC_BITS:0]            frac_o
);
  import swaabb_pkg::*;

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned AW = W + 3;
  localparam logic [F:0] One = {1'b1, {F{1'b0}}};

  logic signed [AW-1:0] pe, me, ce;
  logic signed [AW-1:0] pa_q, ma_q, ca_q, ha_q;

  always_comb begin
    pe = {{3{p_i[W-1]}}, p_i};
    me = {{3{m_i[W-1]}}, m_i};
    ce = {{3{c_i[W-1]}}, c_i};
    if (m_i[W-1]) begin
      pe = -pe;
      me = -me;
      ce = -ce;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q <= pe;
      ma_q <= me;
      ca_q <= ce;
      ha_q <= {4'b0, h_i};
    end
  end

  logic signed [AW-1:0] target, omin, omax, num;
  logic                 sep_b, small_b, nonpos_b, big_b;

  always_comb begin
    target   = pa_q + ma_q;
    omin     = ca_q - ha_q;
    omax     = ca_q + ha_q;
    num      = omin - $signed({{(AW-CfgDataW){1'b0}}, skin_i}) - pa_q;
    sep_b    = (target < omin) || (pa_q >= omax);
    small_b  = ma_q <= $signed({{(AW-CfgDataW){1'b0}}, thr_i});
    nonpos_b = num <= 0;
    big_b    = num >= ma_q;
  end

  logic         sep_q [F+1];
  logic         fix_q [F+1];
  logic [F:0]   fval_q[F+1];
  logic [W-1:0] r_q   [F+1];
  logic [W-1:0] d_q   [F+1];
  logic [F-1:0] qt_q  [F+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sep_q[0]  <= sep_b;
      fix_q[0]  <= sep_b || small_b || nonpos_b || big_b;
      fval_q[0] <= (sep_b || small_b || nonpos_b) ? '0 : One;
      r_q[0]    <= num[W-1:0];
      d_q[0]    <= ma_q[W-1:0];
      qt_q[0]   <= '0;
    end
  end

  for (genvar k = 0; k < F; k++) begin : g_div
    logic [W:0] r2, diff;
    logic       ge;
    always_comb begin
      r2   = {r_q[k], 1'b0};
      diff = r2 - {1'b0, d_q[k]};
      ge   = r2 >= {1'b0, d_q[k]};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sep_q[k+1]  <= sep_q[k];
        fix_q[k+1]  <= fix_q[k];
        fval_q[k+1] <= fval_q[k];
        d_q[k+1]    <= d_q[k];
        r_q[k+1]    <= ge ? diff[W-1:0] : r2[W-1:0];
        qt_q[k+1]   <= {qt_q[k][F-2:0], ge};
      end
    end
  end

  assign sep_o  = sep_q[F];
  assign frac_o = fix_q[F] ? fval_q[F] : {1'b0, qt_q[F]};

endmodule
`default_nettype wire

>>> bench/swept_aabb_fraction_core_test.sv
// ----------------------------------------------------------------------------
// Swept AABB fraction core testbench
// Drives swept point queries against boxes through the pipelined core and
// compares every result beat with a local fixed point predictor, across
// several register settings and sender and receiver idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module swept_aabb_fraction_core_test;
  import swaabb_pkg::*;

  localparam int unsigned CW = 32;
  localparam int unsigned FB = 16;
  localparam int unsigned Latency = FB + 3;

  typedef struct packed {
    logic signed [CW-1:0] sx, sy, mx, my, cx, cy;
    logic [CW-2:0] hw, hh;
  } query_t;

  typedef struct packed {
    logic [FB:0] frac;
    logic hit;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  query_t q_drv = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [FB:0] allowed_fraction_o;
  logic hit_o;

  logic [15:0] skin_q = SkinReset;
  logic [15:0] thresh_q = ThrReset;
  answer_t expected_q[$];
  int errors = 0;
  int beats_out = 0;
  int hits_seen = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  swept_aabb_fraction_core #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) i_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o,
    .start_x_i(q_drv.sx), .start_y_i(q_drv.sy), .move_x_i(q_drv.mx),
    .move_y_i(q_drv.my), .box_center_x_i(q_drv.cx), .box_center_y_i(q_drv.cy),
    .box_half_w_i(q_drv.hw), .box_half_h_i(q_drv.hh),
    .out_valid_o, .out_stall_i, .allowed_fraction_o, .hit_o
  );

  function automatic longint axis_fraction(longint p, longint m, longint c, longint h);
    longint lo_edge, hi_edge, num;
    longint unsigned r, q;
    if (m < 0) begin
      p = -p;
      m = -m;
      c = -c;
    end
    lo_edge = c - h;
    hi_edge = c + h;
    if (p + m < lo_edge || p >= hi_edge) return -1;
    if (m <= longint'(thresh_q)) return 0;
    num = lo_edge - longint'(skin_q) - p;
    if (num <= 0) return 0;
    if (num >= m) return longint'(1) << FB;
    r = num;
    q = 0;
    for (int i = 0; i < FB; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= longint'(m)) begin
        r = r - m;
        q = q | 1;
      end
    end
    return q;
  endfunction

  function automatic answer_t sweep_answer(query_t q);
    longint sx, sy, mx, my, cx, cy, hw, hh, fx, fy, frac;
    logic signed [131:0] d, ext, e1, e2;
    bit sep;
    answer_t a;
    sx = q.sx; sy = q.sy; mx = q.mx; my = q.my; cx = q.cx; cy = q.cy;
    hw = longint'({1'b0, q.hw});
    hh = longint'({1'b0, q.hh});
    frac = 0;
    fx = axis_fraction(sx, mx, cx, hw);
    fy = axis_fraction(sy, my, cy, hh);
    sep = (fx < 0 || fy < 0);
    if (!sep) frac = (fx > fy) ? fx : fy;
    if (!sep && (mx != 0 || my != 0)) begin
      d = (132'(-my) * 132'(sx - cx)) + (132'(mx) * 132'(sy - cy));
      e1 = 132'(hw) * 132'(my);
      e2 = 132'(hh) * 132'(mx);
      if (e1 < 0) e1 = -e1;
      if (e2 < 0) e2 = -e2;
      ext = e1 + e2;
      if (d + ext < 0 || ext - d <= 0) sep = 1;
    end
    if (sep) frac = longint'(1) << FB;
    a.frac = frac[FB:0];
    a.hit = (frac < (longint'(1) << FB));
    return a;
  endfunction

  task automatic send_query(query_t q);
    @(posedge clk_i);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    q_drv <= q;
    do @(posedge clk_i); while (in_stall_o);
    expected_q.insert(expected_q.size(), sweep_answer(q));
    in_valid_i <= 1'b0;
  endtask

  // The single send above drops valid after each accepted beat, so a burst keeps
  // valid continuous between its queries unless an idle gap is drawn.
  task automatic send_burst(query_t qs[$]);
    foreach (qs[i]) begin
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      q_drv <= qs[i];
      do @(posedge clk_i); while (in_stall_o);
      expected_q.insert(expected_q.size(), sweep_answer(qs[i]));
    end
    in_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      beats_out <= beats_out + 1;
      if (hit_o) hits_seen <= hits_seen + 1;
      if (expected_q.size() == 0) begin
        $error("result beat with no query outstanding");
        errors = errors + 1;
      end else begin
        want = expected_q.pop_front();
        if (allowed_fraction_o !== want.frac) begin
          $error("allowed_fraction expected %0d got %0d", want.frac, allowed_fraction_o);
          errors = errors + 1;
        end
        if (hit_o !== want.hit) begin
          $error("hit expected %0d got %0d", want.hit, hit_o);
          errors = errors + 1;
        end
      end
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [15:0] val);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgSkinMargin) skin_q = val;
    else thresh_q = val;
  endtask

  function automatic logic signed [CW-1:0] rand_coord(int span);
    case ($urandom_range(7))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return $signed(32'($urandom_range(2 * span))) - span;
    endcase
  endfunction

  function automatic query_t rand_query();
    query_t q;
    int span;
    span = $urandom_range(3) == 0 ? 32'h3fffffff : (1 << $urandom_range(8, 22));
    q.sx = rand_coord(span);
    q.sy = rand_coord(span);
    q.cx = ($urandom_range(3) == 0) ? rand_coord(span) : q.sx + rand_coord(span / 4 + 1);
    q.cy = ($urandom_range(3) == 0) ? rand_coord(span) : q.sy + rand_coord(span / 4 + 1);
    q.mx = ($urandom_range(5) == 0) ? '0 : (q.cx - q.sx) + rand_coord(span / 4 + 1);
    q.my = ($urandom_range(5) == 0) ? '0 : (q.cy - q.sy) + rand_coord(span / 4 + 1);
    if ($urandom_range(9) == 0) q.mx = $urandom_range(1) ? 32'($urandom_range(20)) : -32'($urandom_range(20));
    q.hw = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(span / 4 + 1));
    q.hh = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(span / 4 + 1));
    if ($urandom_range(15) == 0) q.hw = '0;
    return q;
  endfunction

  function automatic query_t mk(int sx, int sy, int mx, int my, int cx, int cy, int hw, int hh);
    query_t q;
    q.sx = sx; q.sy = sy; q.mx = mx; q.my = my; q.cx = cx; q.cy = cy;
    q.hw = 31'(hw); q.hh = 31'(hh);
    return q;
  endfunction

  task automatic test_directed();
    query_t qs[$];
    qs.insert(qs.size(), mk(0, 0, 32'h00040000, 0, 32'h00030000, 0,
                            32'h00010000, 32'h00010000));
    qs.insert(qs.size(), mk(0, 0, 32'h00040000, 32'h00010000, 32'h00030000, 32'h8000,
                            32'h10000, 32'h10000));
    qs.insert(qs.size(), mk(0, 0, 32'h00010000, 0, 32'h00050000, 0, 32'h10000, 32'h10000));
    qs.insert(qs.size(), mk(32'h00060000, 0, 32'h00010000, 0, 32'h00030000, 0,
                            32'h10000, 32'h10000));
    qs.insert(qs.size(), mk(0, 0, 0, 0, 0, 0, 32'h10000, 32'h10000));
    qs.insert(qs.size(), mk(0, 0, 32'h00040000, 0, 32'h00030000, 0, 0, 32'h10000));
    qs.insert(qs.size(), mk(0, 0, 32'h00020000, 0, 32'h00030000, 0, 32'h10000, 32'h10000));
    qs.insert(qs.size(), mk(0, 0, 7, 0, 8, 0, 4, 4));
    qs.insert(qs.size(), mk(0, 0, 8, 0, 8, 0, 4, 4));
    qs.insert(qs.size(), mk(0, 0, -32'h00040000, 0, -32'h00030000, 0,
                            32'h10000, 32'h10000));
    qs.insert(qs.size(), mk(0, 0, 32'h00030000, 32'h00030000, 32'h00020000, 32'h00020000,
                            32'h8000, 32'h8000));
    qs.insert(qs.size(), mk(0, 0, 32'h00040000, 32'h00040000, 32'h00040000, 0,
                            32'h8000, 32'h8000));
    qs.insert(qs.size(), mk(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 0, 0,
                            32'h7fffffff, 32'h7fffffff));
    qs.insert(qs.size(), mk(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                            32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff));
    qs.insert(qs.size(), mk(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                            32'hffffffff, 32'hffffffff, 32'h7fffffff, 32'h7fffffff));
    send_burst(qs);
    write_reg(CfgSkinMargin, 16'd0);
    qs = {};
    qs.insert(qs.size(), mk(0, 0, 32'h00020000, 0, 32'h00030000, 0, 32'h10000, 32'h10000));
    qs.insert(qs.size(), mk(0, 0, 32'h00040000, 0, 32'h00030000, 0, 32'h10000, 32'h10000));
    send_burst(qs);
  endtask

  task automatic test_random(int n, int idle, int stall);
    query_t qs[$];
    send_idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) qs.insert(qs.size(), rand_query());
    send_burst(qs);
  endtask

  task automatic test_backpressure();
    query_t qs[$];
    send_idle_pct = 0;
    stall_pct = 0;
    @(posedge clk_i);
    hold_cycles <= 60;
    for (int i = 0; i < 40; i++) qs.insert(qs.size(), rand_query());
    send_burst(qs);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    write_reg(CfgSkinMargin, 16'hffff);
    write_reg(CfgParThresh, 16'hffff);
    test_random(110, 0, 0);
    write_reg(CfgSkinMargin, 16'd0);
    write_reg(CfgParThresh, 16'd0);
    test_random(110, 59, 0);
    write_reg(CfgSkinMargin, 16'($urandom));
    write_reg(CfgParThresh, 16'($urandom_range(300)));
    test_random(110, 0, 59);
    write_reg(CfgSkinMargin, SkinReset);
    write_reg(CfgParThresh, ThrReset);
    test_random(110, 31, 31);
    test_backpressure();
    test_random(120, 0, 0);
    send_idle_pct = 0;
    stall_pct = 0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 5) @(posedge clk_i);
    $display("covered %0d result beats, %0d with a hit, over five register settings",
             beats_out, hits_seen);
    $display("with sender gaps, receiver stalls and one long output hold-off");
    if (errors == 0) begin
      $display("swept_aabb_fraction_core_test: PASS");
    end else begin
      $display("swept_aabb_fraction_core_test: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("swept_aabb_fraction_core_test: FAIL");
    $finish;
  end

endmodule
`default_nettype wire
